// File: hdl/lwg_pkg.sv
// lwg_pkg: shared constants, controller states and command/status structs
// for the line walk window origin generator; no dependencies
package lwg_pkg;

	localparam int COORD_BITS   = 12;
	localparam int FRAC_BITS    = 16;
	localparam int ACC_BITS     = COORD_BITS + FRAC_BITS + 1;
	localparam int SLOPE_BITS   = FRAC_BITS + 1;
	localparam int WIDTH_BITS   = 13;
	localparam int ADDR_BITS    = 24;
	localparam int DIV_CNT_BITS = $clog2(SLOPE_BITS + 1);
	localparam int PROD_BITS    = (COORD_BITS + WIDTH_BITS > ADDR_BITS) ?
		COORD_BITS + WIDTH_BITS : ADDR_BITS;

	localparam logic [WIDTH_BITS-1:0] WIDTH_RESET = WIDTH_BITS'(640);
	localparam logic [SLOPE_BITS-1:0] SLOPE_ONE   = SLOPE_BITS'(1) << FRAC_BITS;
	localparam logic [ACC_BITS-1:0]   HALF_LSB    = ACC_BITS'(1) << (FRAC_BITS - 1);

	localparam logic FUNC_BEGIN = 1'b0;
	localparam logic FUNC_STEP  = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_ORG,
		ST_MUL,
		ST_EMIT
	} lwg_state_t;

	typedef struct packed {
		logic take;
		logic div_start;
		logic load_slope;
		logic org_en;
		logic mul_en;
		logic out_load;
	} lwg_cmd_t;

	typedef struct packed {
		logic is_begin;
		logic degenerate;
		logic div_busy;
		logic out_free;
	} lwg_sts_t;

endpackage

// File: hdl/lwg_if.sv
// lwg_item_if and lwg_origin_if: valid/ready channels for input words and
// origin words; depend on lwg_pkg for field widths
interface lwg_item_if;
	import lwg_pkg::*;

	logic                  valid;
	logic                  ready;
	logic                  func;
	logic [COORD_BITS-1:0] start_x;
	logic [COORD_BITS-1:0] start_y;
	logic [COORD_BITS-1:0] end_x;
	logic [COORD_BITS-1:0] end_y;

	modport source (output valid, func, start_x, start_y, end_x, end_y, input ready);
	modport sink (input valid, func, start_x, start_y, end_x, end_y, output ready);
endinterface

interface lwg_origin_if;
	import lwg_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [COORD_BITS-1:0] origin_x;
	logic [COORD_BITS-1:0] origin_y;
	logic [ADDR_BITS-1:0]  base_address;
	logic                  last;
	logic                  stale;

	modport source (output valid, origin_x, origin_y, base_address, last, stale, input ready);
	modport sink (input valid, origin_x, origin_y, base_address, last, stale, output ready);
endinterface

// File: hdl/line_walk_window_origin_generator.sv
// step word: passes ST_ORG, ST_MUL and ST_EMIT; a new word waits for ST_IDLE
// begin word with distinct endpoints: waits in ST_DIV for the slope divider
// (one quotient bit per cycle over FRAC_BITS+1 bits); equal endpoints as a step
// a stalled result holds the output register; the next word waits behind it
// arst_n clears the walk state to origin (0,0), x major, no active walk,
// and image_width to 640
module line_walk_window_origin_generator (
	input  logic                           clk,
	input  logic                           arst_n,
	lwg_item_if.sink                       item,
	lwg_origin_if.source                   origin,
	input  logic                           cfg_we,
	input  logic [lwg_pkg::WIDTH_BITS-1:0] cfg_wdata
);
	import lwg_pkg::*;

	lwg_cmd_t cmd;
	lwg_sts_t sts;

	lwg_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item.valid),
		.item_ready (item.ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	lwg_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.func      (item.func),
		.start_x   (item.start_x),
		.start_y   (item.start_y),
		.end_x     (item.end_x),
		.end_y     (item.end_y),
		.origin    (origin)
	);

endmodule

// File: hdl/lwg_div.sv
// lwg_div: restoring divider giving (minor << FRAC_BITS) / major, one
// quotient bit per cycle; depends on lwg_pkg
module lwg_div (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic [lwg_pkg::COORD_BITS-1:0] minor,
	input  logic [lwg_pkg::COORD_BITS-1:0] major,
	output logic                           busy,
	output logic [lwg_pkg::SLOPE_BITS-1:0] quotient
);
	import lwg_pkg::*;

	logic                    busy_q;
	logic [DIV_CNT_BITS-1:0] cnt_q;
	logic [COORD_BITS:0]     rem_q;
	logic [COORD_BITS-1:0]   div_q;
	logic [SLOPE_BITS-1:0]   quo_q;
	logic                    ge;
	logic [COORD_BITS:0]     rem_next;

	// minor <= major, so the first bit needs no shift and rem stays below 2*major
	assign ge       = rem_q >= {1'b0, div_q};
	assign rem_next = ge ? rem_q - {1'b0, div_q} : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= DIV_CNT_BITS'(SLOPE_BITS);
		end else if (busy_q) begin
			busy_q <= cnt_q != DIV_CNT_BITS'(1);
			cnt_q  <= cnt_q - DIV_CNT_BITS'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, minor};
			div_q <= major;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= {rem_next[COORD_BITS-1:0], 1'b0};
			quo_q <= {quo_q[SLOPE_BITS-2:0], ge};
		end
	end

	assign busy     = busy_q;
	assign quotient = quo_q;

`ifndef SYNTHESIS
	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> rem_q < {div_q, 1'b0})
		else $error("divider remainder out of range");
`endif

endmodule

// File: hdl/lwg_dp.sv
// lwg_dp: walk state, slope divider, origin rounding, address multiply and
// output register; depends on lwg_pkg, lwg_if and lwg_div
module lwg_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  lwg_pkg::lwg_cmd_t              cmd,
	output lwg_pkg::lwg_sts_t              sts,
	input  logic                           cfg_we,
	input  logic [lwg_pkg::WIDTH_BITS-1:0] cfg_wdata,
	input  logic                           func,
	input  logic [lwg_pkg::COORD_BITS-1:0] start_x,
	input  logic [lwg_pkg::COORD_BITS-1:0] start_y,
	input  logic [lwg_pkg::COORD_BITS-1:0] end_x,
	input  logic [lwg_pkg::COORD_BITS-1:0] end_y,
	lwg_origin_if.source                   origin
);
	import lwg_pkg::*;

	logic [WIDTH_BITS-1:0] width_q;
	logic [COORD_BITS-1:0] major_pos_q;
	logic [COORD_BITS-1:0] major_end_q;
	logic [ACC_BITS-1:0]   minor_acc_q;
	logic [SLOPE_BITS-1:0] slope_frac_q;
	logic                  x_is_major_q;
	logic                  major_down_q;
	logic                  minor_down_q;
	logic                  walk_active_q;
	logic                  last_q;
	logic                  stale_q;

	logic [COORD_BITS-1:0] org_x_s1;
	logic [COORD_BITS-1:0] org_y_s1;
	logic [ADDR_BITS-1:0]  prod_s2;
	logic [COORD_BITS-1:0] org_x_s2;

	logic                  out_valid_q;
	logic [COORD_BITS-1:0] out_x_q;
	logic [COORD_BITS-1:0] out_y_q;
	logic [ADDR_BITS-1:0]  out_addr_q;
	logic                  out_last_q;
	logic                  out_stale_q;

	logic [COORD_BITS-1:0] adx, ady, amaj, amin;
	logic                  x_major_in;
	logic [COORD_BITS-1:0] step_major;
	logic [ACC_BITS-1:0]   step_acc;
	logic [ACC_BITS-1:0]   acc_rnd;
	logic [COORD_BITS-1:0] minor_now;
	logic [PROD_BITS-1:0]  prod_full;
	logic                  div_busy;
	logic [SLOPE_BITS-1:0] div_quo;

	// begin decode
	always_comb begin
		adx        = (start_x > end_x) ? start_x - end_x : end_x - start_x;
		ady        = (start_y > end_y) ? start_y - end_y : end_y - start_y;
		x_major_in = ady <= adx;
		amaj       = x_major_in ? adx : ady;
		amin       = x_major_in ? ady : adx;
	end

	always_comb begin
		step_major = major_down_q ? major_pos_q - COORD_BITS'(1) : major_pos_q + COORD_BITS'(1);
		step_acc   = minor_down_q ? minor_acc_q - ACC_BITS'(slope_frac_q)
		                          : minor_acc_q + ACC_BITS'(slope_frac_q);
		acc_rnd    = minor_acc_q + HALF_LSB;
		minor_now  = acc_rnd[FRAC_BITS +: COORD_BITS];
	end

	lwg_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.minor    (amin),
		.major    (amaj),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= WIDTH_RESET;
		end else if (cfg_we) begin
			width_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			major_pos_q   <= '0;
			major_end_q   <= '0;
			minor_acc_q   <= '0;
			slope_frac_q  <= '0;
			x_is_major_q  <= 1'b1;
			major_down_q  <= 1'b0;
			minor_down_q  <= 1'b0;
			walk_active_q <= 1'b0;
			last_q        <= 1'b0;
			stale_q       <= 1'b0;
		end else if (cmd.take) begin
			if (func == FUNC_BEGIN) begin
				x_is_major_q  <= x_major_in;
				major_pos_q   <= x_major_in ? start_x : start_y;
				major_end_q   <= x_major_in ? end_x : end_y;
				major_down_q  <= x_major_in ? (end_x < start_x) : (end_y < start_y);
				minor_down_q  <= x_major_in ? (end_y < start_y) : (end_x < start_x);
				minor_acc_q   <= {1'b0, (x_major_in ? start_y : start_x), FRAC_BITS'(0)};
				slope_frac_q  <= '0;
				walk_active_q <= amaj != '0;
				last_q        <= amaj == '0;
				stale_q       <= 1'b0;
			end else if (walk_active_q) begin
				major_pos_q   <= step_major;
				minor_acc_q   <= step_acc;
				walk_active_q <= step_major != major_end_q;
				last_q        <= step_major == major_end_q;
				stale_q       <= 1'b0;
			end else begin
				last_q  <= 1'b0;
				stale_q <= 1'b1;
			end
		end else if (cmd.load_slope) begin
			slope_frac_q <= div_quo;
		end
	end

	assign prod_full = PROD_BITS'(org_y_s1) * PROD_BITS'(width_q);

	always_ff @(posedge clk) begin
		if (cmd.org_en) begin
			org_x_s1 <= x_is_major_q ? major_pos_q : minor_now;
			org_y_s1 <= x_is_major_q ? minor_now : major_pos_q;
		end
		if (cmd.mul_en) begin
			prod_s2  <= prod_full[ADDR_BITS-1:0];
			org_x_s2 <= org_x_s1;
		end
		if (cmd.out_load) begin
			out_x_q     <= org_x_s2;
			out_y_q     <= org_y_s1;
			out_addr_q  <= prod_s2 + ADDR_BITS'(org_x_s2);
			out_last_q  <= last_q;
			out_stale_q <= stale_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (origin.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign origin.valid        = out_valid_q;
	assign origin.origin_x     = out_x_q;
	assign origin.origin_y     = out_y_q;
	assign origin.base_address = out_addr_q;
	assign origin.last         = out_last_q;
	assign origin.stale        = out_stale_q;

	always_comb begin
		sts.is_begin   = func == FUNC_BEGIN;
		sts.degenerate = amaj == '0;
		sts.div_busy   = div_busy;
		sts.out_free   = !out_valid_q || origin.ready;
	end

`ifndef SYNTHESIS
	a_slope_max: assert property (@(posedge clk) disable iff (!arst_n)
		slope_frac_q <= SLOPE_ONE)
		else $error("slope above one");
	a_stale_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_stale_q |-> !out_last_q)
		else $error("stale word flagged last");
	a_walk_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.take && walk_active_q && func == FUNC_STEP && step_major == major_end_q
		|=> !walk_active_q && last_q)
		else $error("walk still active after end point");
`endif

endmodule

// File: hdl/lwg_ctrl.sv
// lwg_ctrl: sequencer for accept, slope division, origin, multiply and emit
// steps; depends on lwg_pkg
module lwg_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_ready,
	input  lwg_pkg::lwg_sts_t sts,
	output lwg_pkg::lwg_cmd_t cmd
);
	import lwg_pkg::*;

	lwg_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d    = state_q;
		cmd        = '0;
		item_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_ready = 1'b1;
				if (item_valid) begin
					cmd.take = 1'b1;
					if (sts.is_begin && !sts.degenerate) begin
						cmd.div_start = 1'b1;
						state_d       = ST_DIV;
					end else begin
						state_d = ST_ORG;
					end
				end
			end
			ST_DIV: begin
				if (!sts.div_busy) begin
					cmd.load_slope = 1'b1;
					state_d        = ST_ORG;
				end
			end
			ST_ORG: begin
				cmd.org_en = 1'b1;
				state_d    = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul_en = 1'b1;
				state_d    = ST_EMIT;
			end
			ST_EMIT: begin
				// wait for the output register to free up
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

`ifndef SYNTHESIS
	a_idle_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE |-> !sts.div_busy)
		else $error("divider busy while idle");
	a_div_entry: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |=> state_q == ST_DIV && sts.div_busy)
		else $error("division started without wait state");
`endif

endmodule

// File: tb/lwg_origin_checker.sv
// lwg_origin_checker: watches the item, origin and width-write ports, predicts
// every origin word and compares it; depends on lwg_pkg and lwg_if
module lwg_origin_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	lwg_item_if                            item,
	lwg_origin_if                          origin,
	input  logic                           cfg_we,
	input  logic [lwg_pkg::WIDTH_BITS-1:0] cfg_wdata,
	output int                             mismatches,
	output int                             pending
);
	timeunit 1ns;
	timeprecision 1ps;
	import lwg_pkg::*;

	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
		logic [ADDR_BITS-1:0]  addr;
		logic                  last;
		logic                  stale;
	} origin_word_t;

	origin_word_t origin_q[$];

	// walk state mirrored from the line stepper
	logic [WIDTH_BITS-1:0] line_width;
	logic [COORD_BITS-1:0] cur_major;
	logic [COORD_BITS-1:0] end_major;
	logic [ACC_BITS-1:0]   minor_fix;
	logic [SLOPE_BITS-1:0] slope_q;
	logic                  x_major;
	logic                  major_dec;
	logic                  minor_dec;
	logic                  walking;
	int                    err_cnt;

	function automatic origin_word_t current_origin(input logic is_last, input logic is_stale);
		origin_word_t w;
		logic [63:0] rnd;
		logic [63:0] lin;
		logic [COORD_BITS-1:0] mi;
		rnd = 64'(minor_fix) + 64'(HALF_LSB);
		mi = rnd[FRAC_BITS +: COORD_BITS];
		w.x = x_major ? cur_major : mi;
		w.y = x_major ? mi : cur_major;
		lin = 64'(w.y) * 64'(line_width) + 64'(w.x);
		w.addr = lin[ADDR_BITS-1:0];
		w.last = is_last;
		w.stale = is_stale;
		return w;
	endfunction

	function automatic origin_word_t next_origin(input logic f,
			input logic [COORD_BITS-1:0] sx, input logic [COORD_BITS-1:0] sy,
			input logic [COORD_BITS-1:0] ex, input logic [COORD_BITS-1:0] ey);
		logic [COORD_BITS-1:0] adx, ady, amaj, amin, smin;
		if (f == FUNC_BEGIN) begin
			adx = (sx > ex) ? sx - ex : ex - sx;
			ady = (sy > ey) ? sy - ey : ey - sy;
			x_major = (ady <= adx);
			if (x_major) begin
				cur_major = sx;
				end_major = ex;
				major_dec = ex < sx;
				smin = sy;
				minor_dec = ey < sy;
				amaj = adx;
				amin = ady;
			end else begin
				cur_major = sy;
				end_major = ey;
				major_dec = ey < sy;
				smin = sx;
				minor_dec = ex < sx;
				amaj = ady;
				amin = adx;
			end
			slope_q = (amaj != '0) ?
				SLOPE_BITS'((64'(amin) << FRAC_BITS) / 64'(amaj)) : '0;
			minor_fix = ACC_BITS'(64'(smin) << FRAC_BITS);
			walking = (amaj != '0);
			return current_origin(!walking, 1'b0);
		end
		if (!walking)
			return current_origin(1'b0, 1'b1);
		cur_major = major_dec ? cur_major - 1'b1 : cur_major + 1'b1;
		minor_fix = minor_dec ? minor_fix - ACC_BITS'(slope_q) : minor_fix + ACC_BITS'(slope_q);
		if (cur_major == end_major)
			walking = 1'b0;
		return current_origin(cur_major == end_major, 1'b0);
	endfunction

	task automatic match_field(input string name, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			$error("%s mismatch: expected %0d, actual %0d", name, want, got);
			err_cnt++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		origin_word_t want;
		origin_word_t got;
		if (!arst_n) begin
			line_width = WIDTH_RESET;
			cur_major = '0;
			end_major = '0;
			minor_fix = '0;
			slope_q = '0;
			x_major = 1'b1;
			major_dec = 1'b0;
			minor_dec = 1'b0;
			walking = 1'b0;
			origin_q.delete();
			pending <= 0;
		end else begin
			if (cfg_we)
				line_width = cfg_wdata;
			if (origin.valid && origin.ready) begin
				got = {origin.origin_x, origin.origin_y, origin.base_address,
					origin.last, origin.stale};
				if (origin_q.size() == 0) begin
					$error("origin word with none expected: x %0d y %0d", got.x, got.y);
					err_cnt++;
				end else begin
					want = origin_q.pop_front();
					match_field("origin_x", want.x, got.x);
					match_field("origin_y", want.y, got.y);
					match_field("base_address", want.addr, got.addr);
					match_field("last", want.last, got.last);
					match_field("stale", want.stale, got.stale);
				end
			end
			if (item.valid && item.ready)
				origin_q.insert(origin_q.size(), next_origin(item.func, item.start_x,
					item.start_y, item.end_x, item.end_y));
			pending <= origin_q.size();
		end
		mismatches <= err_cnt;
	end

endmodule

// File: tb/tb_line_walk_window_origin_generator.sv
// tb_line_walk_window_origin_generator: drives line walks and width writes
// into the origin generator and reports the verdict from lwg_origin_checker;
// depends on lwg_pkg, lwg_if and the generator RTL
module tb_line_walk_window_origin_generator;
	timeunit 1ns;
	timeprecision 1ps;
	import lwg_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 1000000;
	localparam int          PHASE_WORDS = 225;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [WIDTH_BITS-1:0] cfg_wdata;
	int                    mismatches;
	int                    pending;
	int                    phase_words;
	int                    rx_hold;
	int unsigned           cycles;
	bit                    quiet;

	lwg_item_if   item_ch ();
	lwg_origin_if origin_ch ();

	line_walk_window_origin_generator u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item_ch),
		.origin    (origin_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	lwg_origin_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item_ch),
		.origin     (origin_ch),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.mismatches (mismatches),
		.pending    (pending)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// mostly no gap, then mostly short ones, now and then a long one
	function automatic int pick_gap(input int idle_pct);
		int r;
		r = $urandom_range(99);
		if (r >= idle_pct)
			return 0;
		if ($urandom_range(3) != 0)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int near(input int c, input int r);
		int lo, hi;
		lo = (c > r) ? c - r : 0;
		hi = (c + r < 4095) ? c + r : 4095;
		return $urandom_range(hi, lo);
	endfunction

	always @(posedge clk) begin
		int gap;
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
		if (rx_hold > 0) begin
			origin_ch.ready <= 1'b0;
			rx_hold <= rx_hold - 1;
		end else begin
			gap = quiet ? 0 : pick_gap(15);
			origin_ch.ready <= (gap == 0);
			rx_hold <= (gap > 0) ? gap - 1 : 0;
		end
	end

	task automatic offer_word(input logic f, input int sx, input int sy,
			input int ex, input int ey);
		int gap;
		gap = quiet ? 0 : pick_gap(40);
		if (gap > 0) begin
			item_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		item_ch.valid <= 1'b1;
		item_ch.func <= f;
		item_ch.start_x <= COORD_BITS'(sx);
		item_ch.start_y <= COORD_BITS'(sy);
		item_ch.end_x <= COORD_BITS'(ex);
		item_ch.end_y <= COORD_BITS'(ey);
		@(posedge clk);
		while (!item_ch.ready)
			@(posedge clk);
		phase_words++;
	endtask

	task automatic begin_line(input int sx, input int sy, input int ex, input int ey);
		offer_word(FUNC_BEGIN, sx, sy, ex, ey);
	endtask

	// coordinates on a step word are don't-care, so they get noise
	task automatic step_line();
		offer_word(FUNC_STEP, $urandom_range(4095), $urandom_range(4095),
			$urandom_range(4095), $urandom_range(4095));
	endtask

	// holds the sender until every origin word has been taken
	task automatic settle();
		item_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	task automatic set_width(input int w);
		cfg_we <= 1'b1;
		cfg_wdata <= WIDTH_BITS'(w);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_line();
		int kind, sx, sy, ex, ey, len, n, r;
		kind = $urandom_range(99);
		sx = $urandom_range(4095);
		sy = $urandom_range(4095);
		if (kind < 70) begin
			n = $urandom_range(1, 24);
			ex = near(sx, n);
			ey = near(sy, n);
		end else if (kind < 80) begin
			ex = $urandom_range(4095);
			ey = $urandom_range(4095);
		end else if (kind < 88) begin
			ex = sx;
			ey = sy;
		end else begin
			if ($urandom_range(1))
				step_line();
			else
				begin_line(sx, sy, $urandom_range(4095), $urandom_range(4095));
			return;
		end
		len = (ex > sx) ? ex - sx : sx - ex;
		n = (ey > sy) ? ey - sy : sy - ey;
		if (n > len)
			len = n;
		begin_line(sx, sy, ex, ey);
		r = $urandom_range(9);
		if (kind >= 70 && kind < 80) begin
			// long line, abandoned early
			n = $urandom_range(0, 30);
			if (n > len)
				n = len;
		end else if (r < 7)
			n = len;
		else if (r < 9)
			n = len + $urandom_range(1, 2);
		else
			n = $urandom_range(0, len);
		repeat (n) step_line();
	endtask

	initial begin
		int widths[6];
		arst_n <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		item_ch.valid <= 1'b0;
		item_ch.func <= FUNC_BEGIN;
		item_ch.start_x <= '0;
		item_ch.start_y <= '0;
		item_ch.end_x <= '0;
		item_ch.end_y <= '0;
		quiet = 1'b0;
		phase_words = 0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed lines at the reset width
		step_line();
		begin_line(0, 0, 0, 0);
		begin_line(4095, 4095, 4095, 4095);
		step_line();
		begin_line(0, 0, 3, 0);
		repeat (3) step_line();
		step_line();
		begin_line(10, 20, 12, 14);
		repeat (6) step_line();
		begin_line(4095, 0, 4092, 3);
		repeat (2) step_line();
		begin_line(0, 4095, 4095, 0);
		step_line();
		begin_line(100, 200, 101, 0);
		step_line();
		// half-way accumulators, rising and falling minor
		begin_line(0, 0, 2, 1);
		step_line();
		begin_line(0, 1, 2, 0);
		step_line();

		widths = '{1, 4096, 0, 8191, $urandom_range(1, 4096), $urandom_range(1, 4096)};
		foreach (widths[i]) begin
			settle();
			set_width(widths[i]);
			quiet = (i == 2);
			phase_words = 0;
			while (phase_words < PHASE_WORDS)
				random_line();
		end
		settle();
		repeat (40) @(posedge clk);
		if (mismatches == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
